[design/utf8_decoder_to_cp437_macros.svh]
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// shared property forms for the decoder checks
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODER_TO_CP437_MACROS_SVH
`define UTF8_DECODER_TO_CP437_MACROS_SVH

// same-cycle implication, off during reset
`define U8C_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define U8C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/u8c_pkg.sv]
// ----------------------------------------------------------------------------
// u8c_pkg
// types, codes and decode functions for the utf8 to cp437 decoder
// ----------------------------------------------------------------------------
package u8c_pkg;

	localparam int unsigned CP_W  = 21;
	localparam int unsigned ACC_W = 21;

	typedef enum logic [3:0] {
		ST_ACCEPT  = 4'd0,
		ST_REJECT  = 4'd1,
		ST_NEED1   = 4'd2,
		ST_NEED2   = 4'd3,
		ST_E0_2ND  = 4'd4,
		ST_ED_2ND  = 4'd5,
		ST_F0_2ND  = 4'd6,
		ST_F1_2ND  = 4'd7,
		ST_F4_2ND  = 4'd8
	} dfa_state_t;

	typedef enum logic [3:0] {
		CLS_ASCII    = 4'd0,
		CLS_CONT_LO  = 4'd1,
		CLS_LEAD2    = 4'd2,
		CLS_LEAD3    = 4'd3,
		CLS_ED       = 4'd4,
		CLS_F4       = 4'd5,
		CLS_F1F3     = 4'd6,
		CLS_CONT_HI  = 4'd7,
		CLS_BAD      = 4'd8,
		CLS_CONT_MID = 4'd9,
		CLS_E0       = 4'd10,
		CLS_F0       = 4'd11
	} byte_class_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_MORE   = 2'd1,
		STAT_REJECT = 2'd2
	} status_t;

	localparam logic [7:0] CP437_UNMAPPED = 8'h3F;

	function automatic byte_class_t byte_class(input logic [7:0] b);
		byte_class_t c;
		if (b < 8'h80)       c = CLS_ASCII;
		else if (b < 8'h90)  c = CLS_CONT_LO;
		else if (b < 8'hA0)  c = CLS_CONT_MID;
		else if (b < 8'hC0)  c = CLS_CONT_HI;
		else if (b < 8'hC2)  c = CLS_BAD;
		else if (b < 8'hE0)  c = CLS_LEAD2;
		else if (b == 8'hE0) c = CLS_E0;
		else if (b == 8'hED) c = CLS_ED;
		else if (b < 8'hF0)  c = CLS_LEAD3;
		else if (b == 8'hF0) c = CLS_F0;
		else if (b < 8'hF4)  c = CLS_F1F3;
		else if (b == 8'hF4) c = CLS_F4;
		else                 c = CLS_BAD;
		return c;
	endfunction

	function automatic dfa_state_t next_state(input dfa_state_t s, input byte_class_t c);
		logic lo;
		logic mid;
		logic hi;
		logic any_cont;
		dfa_state_t n;
		lo       = (c == CLS_CONT_LO);
		mid      = (c == CLS_CONT_MID);
		hi       = (c == CLS_CONT_HI);
		any_cont = lo | mid | hi;
		unique case (s)
			ST_ACCEPT: begin
				unique case (c)
					CLS_ASCII: n = ST_ACCEPT;
					CLS_LEAD2: n = ST_NEED1;
					CLS_LEAD3: n = ST_NEED2;
					CLS_ED:    n = ST_ED_2ND;
					CLS_F4:    n = ST_F4_2ND;
					CLS_F1F3:  n = ST_F1_2ND;
					CLS_E0:    n = ST_E0_2ND;
					CLS_F0:    n = ST_F0_2ND;
					default:   n = ST_REJECT;
				endcase
			end
			ST_NEED1:  n = any_cont ? ST_ACCEPT : ST_REJECT;
			ST_NEED2:  n = any_cont ? ST_NEED1 : ST_REJECT;
			ST_E0_2ND: n = hi ? ST_NEED1 : ST_REJECT;
			ST_ED_2ND: n = (lo | mid) ? ST_NEED1 : ST_REJECT;
			ST_F0_2ND: n = (mid | hi) ? ST_NEED2 : ST_REJECT;
			ST_F1_2ND: n = any_cont ? ST_NEED2 : ST_REJECT;
			ST_F4_2ND: n = lo ? ST_NEED2 : ST_REJECT;
			default:   n = ST_REJECT;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] to_cp437(input logic [CP_W-1:0] cp);
		logic [7:0] r;
		if (cp < 21'h80) begin
			r = cp[7:0];
		end else begin
			unique case (cp)
				21'h00C7: r = 8'h80;
				21'h00E7: r = 8'h87;
				21'h011E: r = 8'hA7;
				21'h011F: r = 8'hA6;
				21'h0130: r = 8'hAB;
				21'h0131: r = 8'hAA;
				21'h00D6: r = 8'h99;
				21'h00F6: r = 8'h94;
				21'h015E: r = 8'hA9;
				21'h015F: r = 8'hA8;
				21'h00DC: r = 8'h9A;
				21'h00FC: r = 8'h81;
				default:  r = CP437_UNMAPPED;
			endcase
		end
		return r;
	endfunction

endpackage

[design/utf8_decoder_to_cp437.sv]
// ----------------------------------------------------------------------------
// utf8_decoder_to_cp437
// path: input accept to result valid through the input reg, then the result reg
// throughput: 1 item per cycle while the result is not stalled; the decoder state update sets the rate
// a stalled result holds the input reg, then s_tready drops
// reset: arst_n async low; decoder returns to accept, accumulator zero
// ----------------------------------------------------------------------------
`include "utf8_decoder_to_cp437_macros.svh"

module utf8_decoder_to_cp437
	import u8c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in[7:0]
	input  logic        s_tuser,   // resync
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // code_point[20:0], cp437_char[28:21], zero pad
	output logic [1:0]  m_tuser    // status[1:0]
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        resync_s1;

	dfa_state_t       state_q;
	logic [ACC_W-1:0] acc_q;

	dfa_state_t       state_cur;
	logic [ACC_W-1:0] acc_cur;
	byte_class_t      cls;
	dfa_state_t       state_nxt;
	logic [ACC_W-1:0] acc_nxt;

	status_t          status_d;
	logic [CP_W-1:0]  cp_d;
	logic [7:0]       cp437_d;

	logic             out_adv;
	logic             step;

	assign out_adv  = !m_tvalid || m_tready;
	assign step     = valid_s1 && out_adv;
	assign s_tready = !valid_s1 || out_adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1   <= s_tdata;
			resync_s1 <= s_tuser;
		end
	end

	// next state
	always_comb begin
		state_cur = resync_s1 ? ST_ACCEPT : state_q;
		acc_cur   = resync_s1 ? '0 : acc_q;
		cls       = byte_class(byte_s1);
		if (state_cur != ST_ACCEPT) begin
			acc_nxt = {acc_cur[ACC_W-7:0], byte_s1[5:0]};
		end else begin
			acc_nxt = {{(ACC_W-8){1'b0}}, (8'hFF >> cls) & byte_s1};
		end
		state_nxt = next_state(state_cur, cls);
	end

	// outputs
	always_comb begin
		unique case (state_nxt)
			ST_ACCEPT: begin
				status_d = STAT_DONE;
				cp_d     = acc_nxt;
				cp437_d  = to_cp437(acc_nxt);
			end
			ST_REJECT: begin
				status_d = STAT_REJECT;
				cp_d     = '0;
				cp437_d  = '0;
			end
			default: begin
				status_d = STAT_MORE;
				cp_d     = '0;
				cp437_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_ACCEPT;
			acc_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (step) begin
				state_q <= state_nxt;
				acc_q   <= acc_nxt;
			end
			if (out_adv) begin
				m_tvalid <= valid_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata <= {3'b000, cp437_d, cp_d};
			m_tuser <= status_d;
		end
	end

	`U8C_ASSERT_NOW(a_no_data_unless_done, clk, arst_n,
		m_tvalid && (m_tuser != STAT_DONE), m_tdata == 32'd0,
		"payload not zero on incomplete or rejected item")

	`U8C_ASSERT_NOW(a_cp_in_range, clk, arst_n,
		m_tvalid && (m_tuser == STAT_DONE),
		(m_tdata[20:0] <= 21'h10FFFF)
			&& !((m_tdata[20:0] >= 21'hD800) && (m_tdata[20:0] <= 21'hDFFF)),
		"completed code point is a surrogate or beyond range")

	`U8C_ASSERT_NEXT(a_reject_sticky, clk, arst_n,
		step && (state_q == ST_REJECT) && !resync_s1, m_tuser == STAT_REJECT,
		"reject left without resync")

	`U8C_ASSERT_NOW(a_stall_blocks_input, clk, arst_n,
		valid_s1 && m_tvalid && !m_tready, !s_tready,
		"input taken while result stalled and stage full")

endmodule

[tb/sv/utf8_decoder_to_cp437_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_decoder_to_cp437_test
// feeds byte streams into the utf8 decoder: valid one to four byte forms,
// turkish letters, overlong and surrogate forms, truncated runs, sticky
// reject, resync and raw noise. a local decoder predicts status, code point
// and cp437 byte per item; every result is compared in order.
// ----------------------------------------------------------------------------
module utf8_decoder_to_cp437_test;
	import u8c_pkg::*;

	typedef struct {
		status_t          status;
		logic [CP_W-1:0]  code_point;
		logic [7:0]       cp437_char;
	} decoded_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // byte_in[7:0]
	logic        s_tuser;    // resync
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // code_point[20:0], cp437_char[28:21], zero pad
	logic [1:0]  m_tuser;    // status[1:0]

	decoded_t        pending_chars[$];
	dfa_state_t      model_state;
	logic [ACC_W-1:0] model_acc;
	int              idle_pct;
	int              stall_pct;
	int              bytes_sent;
	int              chars_checked;
	int              rejects_checked;
	int              mismatch_count;

	logic [CP_W-1:0] turkish_cps [12] = '{
		21'h00C7, 21'h00E7, 21'h011E, 21'h011F, 21'h0130, 21'h0131,
		21'h00D6, 21'h00F6, 21'h015E, 21'h015F, 21'h00DC, 21'h00FC
	};

	utf8_decoder_to_cp437 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic byte_class_t classify_byte(input logic [7:0] b);
		if (b[7] == 1'b0)    return CLS_ASCII;
		if (b <= 8'h8F)      return CLS_CONT_LO;
		if (b <= 8'h9F)      return CLS_CONT_MID;
		if (b <= 8'hBF)      return CLS_CONT_HI;
		if (b <= 8'hC1)      return CLS_BAD;
		if (b <= 8'hDF)      return CLS_LEAD2;
		if (b == 8'hE0)      return CLS_E0;
		if (b == 8'hED)      return CLS_ED;
		if (b <= 8'hEF)      return CLS_LEAD3;
		if (b == 8'hF0)      return CLS_F0;
		if (b == 8'hF4)      return CLS_F4;
		if (b <= 8'hF3)      return CLS_F1F3;
		return CLS_BAD;
	endfunction

	function automatic dfa_state_t step_state(input dfa_state_t s, input byte_class_t c);
		logic is_lo;
		logic is_mid;
		logic is_hi;
		is_lo  = (c == CLS_CONT_LO);
		is_mid = (c == CLS_CONT_MID);
		is_hi  = (c == CLS_CONT_HI);
		case (s)
			ST_ACCEPT: begin
				case (c)
					CLS_ASCII: return ST_ACCEPT;
					CLS_LEAD2: return ST_NEED1;
					CLS_LEAD3: return ST_NEED2;
					CLS_E0:    return ST_E0_2ND;
					CLS_ED:    return ST_ED_2ND;
					CLS_F0:    return ST_F0_2ND;
					CLS_F1F3:  return ST_F1_2ND;
					CLS_F4:    return ST_F4_2ND;
					default:   return ST_REJECT;
				endcase
			end
			ST_NEED1:  return (is_lo | is_mid | is_hi) ? ST_ACCEPT : ST_REJECT;
			ST_NEED2:  return (is_lo | is_mid | is_hi) ? ST_NEED1 : ST_REJECT;
			ST_E0_2ND: return is_hi ? ST_NEED1 : ST_REJECT;
			ST_ED_2ND: return (is_lo | is_mid) ? ST_NEED1 : ST_REJECT;
			ST_F0_2ND: return (is_mid | is_hi) ? ST_NEED2 : ST_REJECT;
			ST_F1_2ND: return (is_lo | is_mid | is_hi) ? ST_NEED2 : ST_REJECT;
			ST_F4_2ND: return is_lo ? ST_NEED2 : ST_REJECT;
			default:   return ST_REJECT;
		endcase
	endfunction

	function automatic logic [7:0] cp437_of(input logic [CP_W-1:0] cp);
		if (cp <= 21'h7F)
			return cp[7:0];
		case (cp)
			21'h00C7: return 8'h80;
			21'h00FC: return 8'h81;
			21'h00E7: return 8'h87;
			21'h00F6: return 8'h94;
			21'h00D6: return 8'h99;
			21'h00DC: return 8'h9A;
			21'h011F: return 8'hA6;
			21'h011E: return 8'hA7;
			21'h015F: return 8'hA8;
			21'h015E: return 8'hA9;
			21'h0131: return 8'hAA;
			21'h0130: return 8'hAB;
			default:  return CP437_UNMAPPED;
		endcase
	endfunction

	// advances the local decoder by one accepted item and queues its result
	task automatic decode_byte(input logic [7:0] b, input logic rs);
		byte_class_t cls;
		decoded_t    r;
		if (rs) begin
			model_state = ST_ACCEPT;
			model_acc   = '0;
		end
		cls = classify_byte(b);
		if (model_state != ST_ACCEPT) begin
			model_acc = {model_acc[ACC_W-7:0], b[5:0]};
		end else begin
			model_acc      = '0;
			model_acc[7:0] = (8'hFF >> cls) & b;
		end
		model_state = step_state(model_state, cls);
		if (model_state == ST_ACCEPT) begin
			r.status     = STAT_DONE;
			r.code_point = model_acc;
			r.cp437_char = cp437_of(model_acc);
		end else begin
			r.status     = (model_state == ST_REJECT) ? STAT_REJECT : STAT_MORE;
			r.code_point = '0;
			r.cp437_char = '0;
		end
		pending_chars.push_back(r);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic rs);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= rs;
		do @(posedge clk); while (!s_tready);
		decode_byte(b, rs);
		bytes_sent++;
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			s_tuser  <= 1'($urandom);
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
	endtask

	// shortest utf8 form; resync rides on the lead byte only
	task automatic send_char(input logic [CP_W-1:0] cp, input logic rs);
		if (cp <= 21'h7F) begin
			send_byte(cp[7:0], rs);
		end else if (cp <= 21'h7FF) begin
			send_byte({3'b110, cp[10:6]}, rs);
			send_byte({2'b10, cp[5:0]}, 1'b0);
		end else if (cp <= 21'hFFFF) begin
			send_byte({4'b1110, cp[15:12]}, rs);
			send_byte({2'b10, cp[11:6]}, 1'b0);
			send_byte({2'b10, cp[5:0]}, 1'b0);
		end else begin
			send_byte({5'b11110, cp[20:18]}, rs);
			send_byte({2'b10, cp[17:12]}, 1'b0);
			send_byte({2'b10, cp[11:6]}, 1'b0);
			send_byte({2'b10, cp[5:0]}, 1'b0);
		end
	endtask

	// sender goes idle until every queued result has come back
	task automatic wait_drained;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	function automatic logic [CP_W-1:0] random_cp;
		logic [CP_W-1:0] v;
		case ($urandom_range(4))
			0: v = CP_W'($urandom_range(21'h7F));
			1: v = turkish_cps[4'($urandom_range(11))];
			2: v = CP_W'($urandom_range(21'h80, 21'h7FF));
			3: begin
				v = CP_W'($urandom_range(21'h800, 21'hFFFF));
				if (v >= 21'hD800 && v <= 21'hDFFF)
					v = v ^ 21'h1000;
			end
			default: v = CP_W'($urandom_range(21'h10000, 21'h10FFFF));
		endcase
		return v;
	endfunction

	task automatic test_valid_forms;
		send_char(21'h0, 1'b0);
		send_char(21'h7F, 1'b0);
		send_char(21'h0E7, 1'b0);
		send_char(21'h131, 1'b0);
		send_char(21'h800, 1'b0);
		send_char(21'hD7FF, 1'b0);
		send_char(21'h10000, 1'b0);
		send_char(21'h10FFFF, 1'b0);
	endtask

	task automatic test_reject_and_resync;
		// bad lead, then reject holds while the accumulator wraps
		send_byte(8'hC0, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'h41, 1'b1);
		// truncated two byte form
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		// euro sign after resync maps to the unmapped byte
		send_char(21'h20AC, 1'b1);
	endtask

	task automatic test_random_text(input int sender_idle, input int receiver_stall,
			input int n_bytes);
		int start;
		int pick;
		logic rs;
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		start     = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			pick = $urandom_range(99);
			rs   = (model_state != ST_ACCEPT) ? ($urandom_range(3) != 0)
				: ($urandom_range(9) == 0);
			if (pick < 65) begin
				send_char(random_cp(), rs);
			end else if (pick < 75) begin
				send_byte(8'($urandom_range(8'hC2, 8'hF4)), rs);
				send_byte(8'($urandom), 1'b0);
			end else if (pick < 80) begin
				// surrogate, overlong three byte, above 10ffff
				case ($urandom_range(2))
					0: send_byte(8'hED, rs);
					1: send_byte(8'hE0, rs);
					default: send_byte(8'hF4, rs);
				endcase
				send_byte(model_state == ST_E0_2ND ? 8'($urandom_range(8'h80, 8'h9F))
					: 8'($urandom_range(8'h90, 8'hBF)), 1'b0);
				send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
			end else begin
				send_byte(8'($urandom), 1'($urandom_range(1)));
			end
			if ($urandom_range(49) == 0)
				wait_drained;
		end
		wait_drained;
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				flag_error($sformatf("result with none expected: status %0d data %h",
					m_tuser, m_tdata));
			end else begin
				want = pending_chars.pop_front();
				if (m_tuser !== want.status || m_tdata[20:0] !== want.code_point
						|| m_tdata[28:21] !== want.cp437_char)
					flag_error($sformatf(
						"expected status %0d cp %h char %h, got status %0d cp %h char %h",
						want.status, want.code_point, want.cp437_char,
						m_tuser, m_tdata[20:0], m_tdata[28:21]));
				if (want.status == STAT_DONE)
					chars_checked++;
				else if (want.status == STAT_REJECT)
					rejects_checked++;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = 8'h00;
		s_tuser         = 1'b0;
		m_tready        = 1'b0;
		idle_pct        = 0;
		stall_pct       = 0;
		bytes_sent      = 0;
		chars_checked   = 0;
		rejects_checked = 0;
		mismatch_count  = 0;
		model_state     = ST_ACCEPT;
		model_acc       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_valid_forms;
		test_reject_and_resync;
		wait_drained;
		test_random_text(0, 0, 100);
		test_random_text(79, 0, 100);
		test_random_text(0, 79, 100);
		test_random_text(19, 19, 100);

		idle_pct = 0;
		repeat (20) @(posedge clk);
		if (pending_chars.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_chars.size()));
		$display("sent %0d bytes over four idle/stall mixes: %0d code points, %0d rejects",
			bytes_sent, chars_checked, rejects_checked);
		$display("mismatches: %0d", mismatch_count);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/u8c_pkg.sv
design/utf8_decoder_to_cp437.sv
tb/sv/utf8_decoder_to_cp437_test.sv
